### rtl/core/indexed_circular_deque_unit_assert.svh
// Assertion macros used by the deque RTL.
`ifndef INDEXED_CIRCULAR_DEQUE_UNIT_ASSERT_SVH
`define INDEXED_CIRCULAR_DEQUE_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
`define IDQ_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define IDQ_NEVER(lbl, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define IDQ_ASSERT(lbl, prop, msg)
`define IDQ_NEVER(lbl, cond, msg)
`endif
`endif

### rtl/core/idq_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// idq_pkg
// Command, status and config index codes, field widths and sequencer states of the deque.
// ----------------------------------------------------------------------------
package idq_pkg;

    localparam int CMD_W    = 3;
    localparam int POS_W    = 9;
    localparam int STATUS_W = 2;
    localparam int COUNT_W  = 9;
    localparam int CFG_W    = 9;

    localparam logic [CMD_W-1:0] CMD_INSERT  = 3'd0;
    localparam logic [CMD_W-1:0] CMD_REMOVE  = 3'd1;
    localparam logic [CMD_W-1:0] CMD_REPLACE = 3'd2;
    localparam logic [CMD_W-1:0] CMD_PEEK    = 3'd3;
    localparam logic [CMD_W-1:0] CMD_COMPACT = 3'd4;
    localparam logic [CMD_W-1:0] CMD_REVERSE = 3'd5;
    localparam logic [CMD_W-1:0] CMD_CLEAR   = 3'd6;

    localparam logic [STATUS_W-1:0] STS_OK      = 2'd0;
    localparam logic [STATUS_W-1:0] STS_BAD_IDX = 2'd1;
    localparam logic [STATUS_W-1:0] STS_FULL    = 2'd2;

    localparam logic CFG_INIT_CAP = 1'b0;
    localparam logic CFG_GROW_EN  = 1'b1;

    typedef enum logic [8:0] {
        ST_IDLE = 9'b000000001,
        ST_CHK  = 9'b000000010,
        ST_PEEK = 9'b000000100,
        ST_GET  = 9'b000001000,
        ST_RD   = 9'b000010000,
        ST_RD2  = 9'b000100000,
        ST_WR   = 9'b001000000,
        ST_WR2  = 9'b010000000,
        ST_PUT  = 9'b100000000
    } idq_state_t;

endpackage

### rtl/core/indexed_circular_deque_unit.sv
`timescale 1ns / 1ps
`include "indexed_circular_deque_unit_assert.svh"
// ----------------------------------------------------------------------------
// indexed_circular_deque_unit
// Ring store addressed by logical index with insert, remove, replace, peek,
// compact, reverse and clear, plus capacity growth.
// ----------------------------------------------------------------------------
// One request is worked at a time; s_tready is high only while the sequencer
// is idle. Middle inserts and removals move one entry per ST_RD, ST_WR pair,
// compact reads each stored item and keeps it unless it equals the item
// value, and reverse swaps a pair through ST_RD, ST_RD2, ST_WR and ST_WR2,
// all set by the single memory port and the one slot-address adder shared by
// every step. A finished result waits in the output register while the next
// request is taken. Capacity only bounds the fill level: growth needs no
// repacking, so it costs nothing. Configuration writes empty the store.
module indexed_circular_deque_unit #(
    parameter int DEPTH         = 256,
    parameter int GROWTH_FACTOR = 2,
    parameter int ITEM_WIDTH    = 32,
    localparam int IN_W  = ((idq_pkg::CMD_W + idq_pkg::POS_W + ITEM_WIDTH + 7) / 8) * 8,
    localparam int OUT_W = ((idq_pkg::STATUS_W + idq_pkg::COUNT_W + ITEM_WIDTH + 7) / 8) * 8
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     s_tvalid,
    output logic                     s_tready,
    // command, position, item_value
    input  logic [IN_W-1:0]          s_tdata,
    output logic                     m_tvalid,
    input  logic                     m_tready,
    // status, item_out, item_count
    output logic [OUT_W-1:0]         m_tdata,
    input  logic                     cfg_valid,
    output logic                     cfg_ready,
    input  logic                     cfg_index,
    input  logic [idq_pkg::CFG_W-1:0] cfg_data
);
    import idq_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam int IW = ITEM_WIDTH;
    localparam int GW = CW + 2;
    localparam int INIT_CAP = (16 > DEPTH) ? DEPTH : 16;

    logic [IW-1:0] mem [DEPTH];

    idq_state_t state_reg, state_next;
    logic [AW-1:0] front_reg, front_next;
    logic [CW-1:0] count_reg, count_next;
    logic [CW-1:0] cap_reg, cap_next;
    logic [CW-1:0] init_cap_reg;
    logic          grow_en_reg;
    logic [CMD_W-1:0] cmd_reg, cmd_next;
    logic [POS_W-1:0] pos_reg, pos_next;
    logic [IW-1:0] val_reg, val_next;
    logic [CW-1:0] i_reg, i_next;
    logic [CW-1:0] j_reg, j_next;
    logic [IW-1:0] tmp_reg, tmp_next;
    logic [IW-1:0] item_reg, item_next;
    logic [STATUS_W-1:0] status_reg, status_next;
    logic          done;
    logic [IW-1:0] rdata_reg;
    logic          rd_hold;

    logic          m_valid_reg;
    logic [OUT_W-1:0] m_data_reg;

    logic [CW-1:0] lidx;
    logic [AW:0]   slot_sum;
    logic [AW-1:0] addr;
    logic          we;
    logic [IW-1:0] wdata;
    logic [GW-1:0] grown;
    logic [31:0]   cfg_v;
    logic [CW-1:0] cfg_cap;
    logic          out_free;

    assign s_tready  = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign m_tvalid  = m_valid_reg;
    assign m_tdata   = m_data_reg;
    assign out_free  = !m_valid_reg || m_tready;
    // a stalled final step keeps the read data it is working on
    assign rd_hold   = done && !out_free;

    // shared slot adder: slot = (front + logical) mod DEPTH
    assign slot_sum = {1'b0, front_reg} + (AW + 1)'(lidx);
    assign addr = (slot_sum >= (AW + 1)'(DEPTH)) ? AW'(slot_sum - (AW + 1)'(DEPTH))
                                                 : AW'(slot_sum);

    assign grown = ((GW'(cap_reg) * GW'(GROWTH_FACTOR)) > GW'(DEPTH)) ? GW'(DEPTH)
                 : GW'(cap_reg) * GW'(GROWTH_FACTOR);

    always_comb
    begin
        cfg_v = 32'(cfg_data);
        if (cfg_v == 32'd0)
        begin
            cfg_v = 32'd1;
        end
        if (cfg_v > 32'(DEPTH))
        begin
            cfg_v = 32'(DEPTH);
        end
        cfg_cap = CW'(cfg_v);
    end

    always_comb
    begin
        lidx = i_reg;
        case (state_reg)
            ST_PEEK: lidx = CW'(pos_reg);
            ST_RD:
            begin
                case (cmd_reg)
                    CMD_INSERT: lidx = i_reg - CW'(1);
                    CMD_REMOVE: lidx = i_reg + CW'(1);
                    default:    lidx = i_reg;
                endcase
            end
            ST_RD2:  lidx = j_reg;
            ST_WR:   lidx = (cmd_reg == CMD_COMPACT) ? j_reg : i_reg;
            ST_WR2:  lidx = j_reg;
            default: lidx = i_reg;
        endcase
    end

    always_comb
    begin
        state_next  = state_reg;
        front_next  = front_reg;
        count_next  = count_reg;
        cap_next    = cap_reg;
        cmd_next    = cmd_reg;
        pos_next    = pos_reg;
        val_next    = val_reg;
        i_next      = i_reg;
        j_next      = j_reg;
        tmp_next    = tmp_reg;
        item_next   = item_reg;
        status_next = status_reg;
        done        = 1'b0;
        we          = 1'b0;
        wdata       = rdata_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    cmd_next   = s_tdata[CMD_W-1:0];
                    pos_next   = s_tdata[CMD_W +: POS_W];
                    val_next   = s_tdata[CMD_W + POS_W +: IW];
                    state_next = ST_CHK;
                end
            end
            ST_CHK:
            begin
                item_next   = '0;
                status_next = STS_OK;
                case (cmd_reg)
                    CMD_INSERT:
                    begin
                        if (32'(pos_reg) > 32'(count_reg))
                        begin
                            status_next = STS_BAD_IDX;
                            done = 1'b1;
                        end
                        else if (count_reg >= cap_reg && (!grow_en_reg ||
                                 32'(cap_reg) >= 32'(DEPTH)))
                        begin
                            status_next = STS_FULL;
                            done = 1'b1;
                        end
                        else
                        begin
                            if (count_reg >= cap_reg)
                            begin
                                cap_next = CW'(grown);
                            end
                            if (count_reg == '0)
                            begin
                                front_next = '0;
                                i_next = '0;
                                state_next = ST_PUT;
                            end
                            else if (pos_reg == '0)
                            begin
                                front_next = (front_reg == '0) ? AW'(DEPTH - 1)
                                                               : front_reg - AW'(1);
                                i_next = '0;
                                state_next = ST_PUT;
                            end
                            else if (32'(pos_reg) == 32'(count_reg))
                            begin
                                i_next = count_reg;
                                state_next = ST_PUT;
                            end
                            else
                            begin
                                i_next = count_reg;
                                state_next = ST_RD;
                            end
                        end
                    end
                    CMD_REMOVE, CMD_REPLACE, CMD_PEEK:
                    begin
                        if (32'(pos_reg) >= 32'(count_reg))
                        begin
                            status_next = STS_BAD_IDX;
                            done = 1'b1;
                        end
                        else if (cmd_reg == CMD_REPLACE)
                        begin
                            i_next = CW'(pos_reg);
                            state_next = ST_PUT;
                        end
                        else
                        begin
                            state_next = ST_PEEK;
                        end
                    end
                    CMD_COMPACT:
                    begin
                        if (count_reg == '0)
                        begin
                            done = 1'b1;
                        end
                        else
                        begin
                            i_next = '0;
                            j_next = '0;
                            state_next = ST_RD;
                        end
                    end
                    CMD_REVERSE:
                    begin
                        if (count_reg > CW'(1))
                        begin
                            i_next = '0;
                            j_next = count_reg - CW'(1);
                            state_next = ST_RD;
                        end
                        else
                        begin
                            done = 1'b1;
                        end
                    end
                    CMD_CLEAR:
                    begin
                        front_next = '0;
                        count_next = '0;
                        done = 1'b1;
                    end
                    default:
                    begin
                        done = 1'b1;
                    end
                endcase
            end
            ST_PEEK:
            begin
                state_next = ST_GET;
            end
            ST_GET:
            begin
                item_next = rdata_reg;
                if (cmd_reg == CMD_REMOVE)
                begin
                    if (pos_reg == '0)
                    begin
                        if (count_reg == CW'(1))
                        begin
                            front_next = '0;
                        end
                        else
                        begin
                            front_next = (front_reg == AW'(DEPTH - 1)) ? '0
                                                                        : front_reg + AW'(1);
                        end
                        count_next = count_reg - CW'(1);
                        done = 1'b1;
                    end
                    else if (32'(pos_reg) == 32'(count_reg) - 32'd1)
                    begin
                        count_next = count_reg - CW'(1);
                        done = 1'b1;
                    end
                    else
                    begin
                        i_next = CW'(pos_reg);
                        state_next = ST_RD;
                    end
                end
                else
                begin
                    done = 1'b1;
                end
            end
            ST_RD:
            begin
                state_next = (cmd_reg == CMD_REVERSE) ? ST_RD2 : ST_WR;
            end
            ST_RD2:
            begin
                tmp_next = rdata_reg;
                state_next = ST_WR;
            end
            ST_WR:
            begin
                wdata = rdata_reg;
                case (cmd_reg)
                    CMD_INSERT:
                    begin
                        we = 1'b1;
                        i_next = i_reg - CW'(1);
                        state_next = (32'(i_reg) - 32'd1 > 32'(pos_reg)) ? ST_RD : ST_PUT;
                    end
                    CMD_REMOVE:
                    begin
                        we = 1'b1;
                        i_next = i_reg + CW'(1);
                        if (32'(i_reg) + 32'd2 < 32'(count_reg))
                        begin
                            state_next = ST_RD;
                        end
                        else
                        begin
                            count_next = count_reg - CW'(1);
                            done = 1'b1;
                        end
                    end
                    CMD_COMPACT:
                    begin
                        we = (rdata_reg != val_reg);
                        j_next = (rdata_reg != val_reg) ? j_reg + CW'(1) : j_reg;
                        i_next = i_reg + CW'(1);
                        if (i_reg + CW'(1) == count_reg)
                        begin
                            count_next = j_next;
                            done = 1'b1;
                        end
                        else
                        begin
                            state_next = ST_RD;
                        end
                    end
                    default:
                    begin
                        // reverse: low end gets the high item
                        we = 1'b1;
                        state_next = ST_WR2;
                    end
                endcase
            end
            ST_WR2:
            begin
                we = 1'b1;
                wdata = tmp_reg;
                i_next = i_reg + CW'(1);
                j_next = j_reg - CW'(1);
                if ((CW + 1)'(i_reg) + (CW + 1)'(1) < (CW + 1)'(j_reg) - (CW + 1)'(1))
                begin
                    state_next = ST_RD;
                end
                else
                begin
                    done = 1'b1;
                end
            end
            ST_PUT:
            begin
                we = 1'b1;
                wdata = val_reg;
                if (cmd_reg == CMD_INSERT)
                begin
                    count_next = count_reg + CW'(1);
                end
                done = 1'b1;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        // hold the finished request until the output register is free
        if (done)
        begin
            state_next = out_free ? ST_IDLE : state_reg;
            if (!out_free)
            begin
                we = 1'b0;
                front_next = front_reg;
                count_next = count_reg;
                cap_next = cap_reg;
                i_next = i_reg;
                j_next = j_reg;
                item_next = item_reg;
                status_next = status_reg;
                if (state_reg == ST_CHK)
                begin
                    item_next = '0;
                    status_next = STS_OK;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        if (!rd_hold)
        begin
            rdata_reg <= mem[addr];
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg    <= cmd_next;
        pos_reg    <= pos_next;
        val_reg    <= val_next;
        i_reg      <= i_next;
        j_reg      <= j_next;
        tmp_reg    <= tmp_next;
        item_reg   <= item_next;
        status_reg <= status_next;
        if (done && out_free)
        begin
            m_data_reg <= OUT_W'({COUNT_W'(count_next), item_next, status_next});
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            front_reg    <= '0;
            count_reg    <= '0;
            cap_reg      <= CW'(INIT_CAP);
            init_cap_reg <= CW'(INIT_CAP);
            grow_en_reg  <= 1'b1;
            m_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            front_reg <= front_next;
            count_reg <= count_next;
            cap_reg   <= cap_next;
            if (done && out_free)
            begin
                m_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                m_valid_reg <= 1'b0;
            end
            if (cfg_valid)
            begin
                front_reg <= '0;
                count_reg <= '0;
                if (cfg_index == CFG_INIT_CAP)
                begin
                    init_cap_reg <= cfg_cap;
                    cap_reg      <= cfg_cap;
                end
                else
                begin
                    grow_en_reg <= cfg_data[0];
                    cap_reg     <= init_cap_reg;
                end
            end
        end
    end

    `IDQ_NEVER(a_count_in_cap, count_reg > cap_reg, "item count exceeds capacity in use")
    `IDQ_NEVER(a_cap_range, cap_reg == '0 || 32'(cap_reg) > 32'(DEPTH), "capacity out of range")
    `IDQ_ASSERT(a_compact_order, (state_reg == ST_WR && cmd_reg == CMD_COMPACT) |-> (j_reg <= i_reg), "compact write passes read")
    `IDQ_ASSERT(a_done_shows, (done && out_free) |=> m_tvalid, "finished request not presented")
    `IDQ_NEVER(a_busy_ready, s_tready && state_reg != ST_IDLE, "ready while sequencer busy")

endmodule
